/* rtl/vd3_pkg.sv */
// ----------------------------------------------------------------------------
// vd3_pkg
// Widths and the stage record shared by the 3D distance pipeline.
// ----------------------------------------------------------------------------
package vd3_pkg;

  // Signed Q16.16 coordinate.
  localparam int unsigned COORD_W = 32;
  // Magnitude of one coordinate difference.
  localparam int unsigned MAG_W   = 32;
  // Square of one magnitude.
  localparam int unsigned SQ_W    = 2 * MAG_W;
  // Sum of two squares and sum of three squares.
  localparam int unsigned PSUM_W  = SQ_W + 1;
  localparam int unsigned SUM_W   = SQ_W + 2;
  // Root bits: one per pair of radicand bits.
  localparam int unsigned ROOT_W  = SUM_W / 2;
  // Partial remainder: it never exceeds twice the root, plus two new bits.
  localparam int unsigned REM_W   = ROOT_W + 3;

  // State handed from one square-root stage to the next.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
  } vd3_sqrt_t;

endpackage

/* rtl/vd3_sqsum.sv */
// ----------------------------------------------------------------------------
// vd3_sqsum
// Front end: absolute differences, squares and their exact sum in four stages.
// ----------------------------------------------------------------------------
module vd3_sqsum (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [vd3_pkg::COORD_W-1:0] ax_i,
  input  logic [vd3_pkg::COORD_W-1:0] ay_i,
  input  logic [vd3_pkg::COORD_W-1:0] az_i,
  input  logic [vd3_pkg::COORD_W-1:0] bx_i,
  input  logic [vd3_pkg::COORD_W-1:0] by_i,
  input  logic [vd3_pkg::COORD_W-1:0] bz_i,
  output logic                        valid_o,
  output logic [vd3_pkg::SUM_W-1:0]   sum_o
);
  import vd3_pkg::*;

  logic [COORD_W:0]  dx_w, dy_w, dz_w;
  logic [COORD_W:0]  mx_w, my_w, mz_w;
  logic [MAG_W-1:0]  mx_d, my_d, mz_d;
  logic [MAG_W-1:0]  mx_q, my_q, mz_q;
  logic [SQ_W-1:0]   sx_d, sy_d, sz_d;
  logic [SQ_W-1:0]   sx_q, sy_q, sz_q;
  logic [PSUM_W-1:0] pxy_d, pxy_q;
  logic [SQ_W-1:0]   sz2_q;
  logic [SUM_W-1:0]  sum_d, sum_q;
  logic [3:0]        vld_q;

  // Exact 33-bit differences and their magnitudes, which fit in 32 bits.
  always_comb begin
    dx_w = {ax_i[COORD_W-1], ax_i} - {bx_i[COORD_W-1], bx_i};
    dy_w = {ay_i[COORD_W-1], ay_i} - {by_i[COORD_W-1], by_i};
    dz_w = {az_i[COORD_W-1], az_i} - {bz_i[COORD_W-1], bz_i};
    mx_w = dx_w[COORD_W] ? (~dx_w + 1'b1) : dx_w;
    my_w = dy_w[COORD_W] ? (~dy_w + 1'b1) : dy_w;
    mz_w = dz_w[COORD_W] ? (~dz_w + 1'b1) : dz_w;
    mx_d = mx_w[MAG_W-1:0];
    my_d = my_w[MAG_W-1:0];
    mz_d = mz_w[MAG_W-1:0];
  end

  // One 32x32 multiplier per axis.
  always_comb begin
    sx_d = {{MAG_W{1'b0}}, mx_q} * {{MAG_W{1'b0}}, mx_q};
    sy_d = {{MAG_W{1'b0}}, my_q} * {{MAG_W{1'b0}}, my_q};
    sz_d = {{MAG_W{1'b0}}, mz_q} * {{MAG_W{1'b0}}, mz_q};
  end

  // The three squares are summed over two stages.
  always_comb begin
    pxy_d = {1'b0, sx_q} + {1'b0, sy_q};
    sum_d = {1'b0, pxy_q} + {2'b00, sz2_q};
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mx_q  <= mx_d;
    my_q  <= my_d;
    mz_q  <= mz_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    sz_q  <= sz_d;
    pxy_q <= pxy_d;
    sz2_q <= sz_q;
    sum_q <= sum_d;
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];
  assign sum_o   = sum_q;

endmodule

/* rtl/vd3_sqrt_stage.sv */
// ----------------------------------------------------------------------------
// vd3_sqrt_stage
// One registered step of the digit-by-digit square root: one root bit.
// ----------------------------------------------------------------------------
module vd3_sqrt_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  vd3_pkg::vd3_sqrt_t data_i,
  output logic               valid_o,
  output vd3_pkg::vd3_sqrt_t data_o
);
  import vd3_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;
  vd3_sqrt_t        data_d, data_q;
  logic             valid_q;

  // Bring down the next two radicand bits and test the trial value 4r+1.
  always_comb begin
    rem_sh = {data_i.rem[REM_W-3:0], data_i.rad[SUM_W-1 -: 2]};
    trial  = {1'b0, data_i.root, 2'b01};
    take   = (rem_sh >= trial);
    data_d.rem  = take ? (rem_sh - trial) : rem_sh;
    data_d.root = {data_i.root[ROOT_W-2:0], take};
    data_d.rad  = {data_i.rad[SUM_W-3:0], 2'b00};
  end

  // Payload register.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* rtl/vector_distance_3d_top.sv */
// ----------------------------------------------------------------------------
// vector_distance_3d_top
// Euclidean distance between two 3D points with signed Q16.16 coordinates.
// ----------------------------------------------------------------------------
//  Channel   Handshake         Payload
//  input     start, busy       ax_i ay_i az_i bx_i by_i bz_i (32 b signed)
//  result    done_o (strobe)   distance_o (33 b unsigned Q16.16)
//
//  An item is taken in every cycle that start is high; busy stays low.
//  Each item's result appears on done_o after four front stages
//  (difference, square, two adds) and one stage per root bit for 33 bits.
//  Reset clears only the valid bits; no item is in flight afterwards.
//  Results are never held back, so nothing in the pipeline ever stalls.
// ----------------------------------------------------------------------------
module vector_distance_3d_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [vd3_pkg::COORD_W-1:0]  ax_i,
  input  logic [vd3_pkg::COORD_W-1:0]  ay_i,
  input  logic [vd3_pkg::COORD_W-1:0]  az_i,
  input  logic [vd3_pkg::COORD_W-1:0]  bx_i,
  input  logic [vd3_pkg::COORD_W-1:0]  by_i,
  input  logic [vd3_pkg::COORD_W-1:0]  bz_i,
  output logic                         done_o,
  output logic [vd3_pkg::ROOT_W-1:0]   distance_o
);
  import vd3_pkg::*;

  logic             sum_vld;
  logic [SUM_W-1:0] sum;
  logic             stg_vld  [0:ROOT_W];
  vd3_sqrt_t        stg_data [0:ROOT_W];

  // The pipeline takes an item every cycle.
  assign busy = 1'b0;

  // Differences, squares and the exact sum.
  vd3_sqsum u_sqsum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .ax_i    (ax_i),
    .ay_i    (ay_i),
    .az_i    (az_i),
    .bx_i    (bx_i),
    .by_i    (by_i),
    .bz_i    (bz_i),
    .valid_o (sum_vld),
    .sum_o   (sum)
  );

  // Root pipeline starts with a clear remainder and root.
  always_comb begin
    stg_vld[0]       = sum_vld;
    stg_data[0].rem  = '0;
    stg_data[0].root = '0;
    stg_data[0].rad  = sum;
  end

  // One stage per root bit, most significant first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_root
    vd3_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_vld[k]),
      .data_i  (stg_data[k]),
      .valid_o (stg_vld[k+1]),
      .data_o  (stg_data[k+1])
    );
  end

  assign done_o     = stg_vld[ROOT_W];
  assign distance_o = stg_data[ROOT_W].root;

endmodule
